// File: rtl/arc_length_path_lookup_top_macros.svh
// assertion macros for the arc length path lookup block
`ifndef ARC_LENGTH_PATH_LOOKUP_TOP_MACROS_SVH
`define ARC_LENGTH_PATH_LOOKUP_TOP_MACROS_SVH

// same-cycle implication
`define ALP_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("alp assertion failed");

// next-cycle implication
`define ALP_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("alp assertion failed");

`endif

// File: rtl/alp_pkg.sv
// types, constants and codes shared by the arc length path lookup block
package alp_pkg;

   localparam int ALP_MAX_POINTS  = 1024;
   localparam int ALP_IDX_W       = 17;
   localparam int ALP_QUEUE_DEPTH = 2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FEW      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_SEG = 2'd2;

   typedef struct packed {
      logic               op;
      logic               start_path;
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic [15:0]        point_speed;
      logic [31:0]        query_distance;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic [15:0]        speed;
      logic [1:0]         status;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_FIRST,
      CMD_APPEND,
      CMD_FEW,
      CMD_QUERY
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type         kind;
      logic [ALP_IDX_W-1:0] idx;
      logic [31:0]          x;
      logic [31:0]          y;
      logic [15:0]          speed;
      logic [31:0]          distance;
   } cmd_type;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [15:0] speed;
      logic [31:0] cum;
   } way_type;

   typedef struct packed {
      logic        start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic        busy;
      logic [63:0] quotient;
      logic [31:0] remainder;
   } div_rsp_type;

   typedef enum logic [4:0] {
      BK_IDLE,
      BK_SQ_X,
      BK_SQ_Y,
      BK_SQRT,
      BK_APPEND,
      BK_SRCH,
      BK_SRCH_CMP,
      BK_RD_S,
      BK_RD_E,
      BK_RD_T,
      BK_SEG,
      BK_FRAC_DIV,
      BK_LERP_LO,
      BK_LERP_HI,
      BK_LERP_SUM,
      BK_SPD_MUL,
      BK_SPD_DIV1,
      BK_SPD_DIV2,
      BK_SPD_RD,
      BK_SPD_CAP,
      BK_RESULT
   } back_state_type;

endpackage

// File: rtl/alp_front.sv
// front end: accepts items, tracks point count and classifies them into commands
module alp_front
   import alp_pkg::*;
#(
   parameter int MAX_POINTS = ALP_MAX_POINTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    push_valid,
   input  logic    push_ready,
   output cmd_type push_cmd
);

   localparam int CW = $clog2(MAX_POINTS + 1);

   logic [CW-1:0] cnt_ff, cnt_in, base;
   logic          accept, is_load, full;

   always_comb begin
      accept    = req_valid && push_ready;
      is_load   = (req_data.op == OP_LOAD);
      base      = req_data.start_path ? '0 : cnt_ff;
      full      = (base == CW'(MAX_POINTS));
      req_ready = push_ready;

      push_cmd.x        = req_data.point_x;
      push_cmd.y        = req_data.point_y;
      push_cmd.speed    = req_data.point_speed;
      push_cmd.distance = req_data.query_distance;
      if (is_load) begin
         push_cmd.idx  = ALP_IDX_W'(base);
         push_cmd.kind = (base == '0) ? CMD_FIRST : CMD_APPEND;
      end else begin
         push_cmd.idx  = ALP_IDX_W'(cnt_ff);
         push_cmd.kind = (cnt_ff < CW'(2)) ? CMD_FEW : CMD_QUERY;
      end

      push_valid = accept && !(is_load && full);

      cnt_in = cnt_ff;
      if (accept && is_load && !full) begin
         cnt_in = base + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/alp_queue.sv
// short command queue between front and back end
module alp_queue
   import alp_pkg::*;
#(
   parameter int DEPTH = ALP_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   cmd_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   always_comb begin
      push_ready = (fill_ff != NW'(DEPTH));
      pop_valid  = (fill_ff != '0);
      pop_cmd    = slot_ff[rd_ptr_ff];
      do_push    = push_valid && push_ready;
      do_pop     = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// File: rtl/alp_div.sv
// radix-2 restoring divider, 64-bit dividend by 32-bit divisor
module alp_div
   import alp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic        busy_ff, busy_in, done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in, dvs_ff, dvs_in;
   logic [32:0] rem_sh, rem_sub;
   logic        ge;

   always_comb begin
      rem_sh  = {rem_ff, quo_ff[63]};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      ge      = (rem_sh >= {1'b0, dvs_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;

      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = ge ? rem_sub[31:0] : rem_sh[31:0];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end

      div_rsp.done      = done_ff;
      div_rsp.busy      = busy_ff;
      div_rsp.quotient  = quo_ff;
      div_rsp.remainder = rem_ff;
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

endmodule

// File: rtl/alp_back.sv
// back end: waypoint memory, segment length, search, interpolation and speed lookup
`include "arc_length_path_lookup_top_macros.svh"

module alp_back
   import alp_pkg::*;
#(
   parameter int MAX_POINTS = ALP_MAX_POINTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   output logic        q_ready,
   input  cmd_type     q_cmd,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   output div_req_type div_req,
   input  div_rsp_type div_rsp
);

   localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam logic [40:0] OFF_CAP = 41'h100_0000_0000;

   way_type       mem [MAX_POINTS];
   way_type       rd_q_ff, wr_data;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          mem_we;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [31:0]    last_x_ff, last_x_in, last_y_ff, last_y_in, last_cum_ff, last_cum_in;
   logic [AW-1:0]  s_ff, s_in, e_ff, e_in, mid_ff, mid_in, idx_ff, idx_in;
   logic [31:0]    cs_ff, cs_in, ce_ff, ce_in, xs_ff, xs_in, xe_ff, xe_in;
   logic [31:0]    ys_ff, ys_in, ye_ff, ye_in, total_ff, total_in;
   logic [63:0]    sq_ff, sq_in, plo_ff, plo_in;
   logic [47:0]    phi_ff, phi_in, frac_ff, frac_in;
   logic [65:0]    rad_ff, rad_in;
   logic [34:0]    rem_ff, rem_in;
   logic [32:0]    root_ff, root_in;
   logic [5:0]     it_ff, it_in;
   logic           axis_ff, axis_in;
   logic [31:0]    res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [15:0]    res_speed_ff, res_speed_in;
   logic [1:0]     res_status_ff, res_status_in;
   rsp_type        rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;

   logic [31:0]        mul_a, mul_b;
   logic [63:0]        mul_p;
   logic [36:0]        rem_sh, trial, rem_sub;
   logic [31:0]        seg_len, cum_new;
   logic [32:0]        cum_sum;
   logic [AW:0]        mid_sum;
   logic [31:0]        ps, pe, mag;
   logic [32:0]        diff33, mag33;
   logic               neg;
   logic [79:0]        prod80;
   logic [63:0]        off_full;
   logic [40:0]        off;
   logic signed [42:0] sum43;
   logic [31:0]        lerp_res;

   function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] d;
      d = {a[31], a} - {b[31], b};
      abs_diff = d[32] ? 32'(-d) : d[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_comb begin
      // segment length
      rem_sh  = {rem_ff, rad_ff[65:64]};
      trial   = {2'b00, root_ff, 2'b01};
      rem_sub = rem_sh - trial;
      seg_len = root_ff[32] ? 32'hFFFF_FFFF : root_ff[31:0];
      cum_sum = {1'b0, last_cum_ff} + {1'b0, seg_len};
      cum_new = cum_sum[32] ? 32'hFFFF_FFFF : cum_sum[31:0];

      mid_sum = {1'b0, s_ff} + {1'b0, e_ff};

      // interpolation along one axis
      ps       = axis_ff ? ys_ff : xs_ff;
      pe       = axis_ff ? ye_ff : xe_ff;
      diff33   = {pe[31], pe} - {ps[31], ps};
      neg      = diff33[32];
      mag33    = neg ? -diff33 : diff33;
      mag      = mag33[31:0];
      prod80   = {phi_ff, 32'b0} + {16'b0, plo_ff};
      off_full = prod80[79:16];
      off      = (off_full > 64'(OFF_CAP)) ? OFF_CAP : off_full[40:0];
      sum43    = neg ? ($signed({{11{ps[31]}}, ps}) - $signed({2'b00, off}))
                     : ($signed({{11{ps[31]}}, ps}) + $signed({2'b00, off}));
      if (sum43 > 43'sd2147483647) begin
         lerp_res = 32'h7FFF_FFFF;
      end else if (sum43 < -43'sd2147483648) begin
         lerp_res = 32'h8000_0000;
      end else begin
         lerp_res = sum43[31:0];
      end

      case (state_ff)
         BK_SQ_X: begin
            mul_a = abs_diff(cmd_ff.x, last_x_ff);
            mul_b = mul_a;
         end
         BK_SQ_Y: begin
            mul_a = abs_diff(cmd_ff.y, last_y_ff);
            mul_b = mul_a;
         end
         BK_LERP_LO: begin
            mul_a = frac_ff[31:0];
            mul_b = mag;
         end
         BK_LERP_HI: begin
            mul_a = {16'b0, frac_ff[47:32]};
            mul_b = mag;
         end
         BK_SPD_MUL: begin
            mul_a = cmd_ff.distance;
            mul_b = 32'(cmd_ff.idx);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      mul_p = mul_a * mul_b;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      last_cum_in   = last_cum_ff;
      s_in          = s_ff;
      e_in          = e_ff;
      mid_in        = mid_ff;
      idx_in        = idx_ff;
      cs_in         = cs_ff;
      ce_in         = ce_ff;
      xs_in         = xs_ff;
      xe_in         = xe_ff;
      ys_in         = ys_ff;
      ye_in         = ye_ff;
      total_in      = total_ff;
      sq_in         = sq_ff;
      plo_in        = plo_ff;
      phi_in        = phi_ff;
      frac_in       = frac_ff;
      rad_in        = rad_ff;
      rem_in        = rem_ff;
      root_in       = root_ff;
      it_in         = it_ff;
      axis_in       = axis_ff;
      res_x_in      = res_x_ff;
      res_y_in      = res_y_ff;
      res_speed_in  = res_speed_ff;
      res_status_in = res_status_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      q_ready          = 1'b0;
      mem_we           = 1'b0;
      wr_addr          = '0;
      wr_data          = '0;
      rd_addr          = s_ff;
      div_req.start    = 1'b0;
      div_req.dividend = '0;
      div_req.divisor  = '0;

      case (state_ff)
         BK_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               cmd_in = q_cmd;
               case (q_cmd.kind)
                  CMD_FIRST: begin
                     mem_we      = 1'b1;
                     wr_addr     = '0;
                     wr_data     = {q_cmd.x, q_cmd.y, q_cmd.speed, 32'b0};
                     last_x_in   = q_cmd.x;
                     last_y_in   = q_cmd.y;
                     last_cum_in = '0;
                  end
                  CMD_APPEND: begin
                     state_in = BK_SQ_X;
                  end
                  CMD_FEW: begin
                     res_x_in      = '0;
                     res_y_in      = '0;
                     res_speed_in  = '0;
                     res_status_in = STATUS_FEW;
                     state_in      = BK_RESULT;
                  end
                  default: begin
                     s_in     = '0;
                     e_in     = AW'(q_cmd.idx - ALP_IDX_W'(1));
                     state_in = BK_SRCH;
                  end
               endcase
            end
         end
         BK_SQ_X: begin
            sq_in    = mul_p;
            state_in = BK_SQ_Y;
         end
         BK_SQ_Y: begin
            rad_in   = {1'b0, {1'b0, sq_ff} + {1'b0, mul_p}};
            rem_in   = '0;
            root_in  = '0;
            it_in    = '0;
            state_in = BK_SQRT;
         end
         BK_SQRT: begin
            if (rem_sh >= trial) begin
               rem_in  = rem_sub[34:0];
               root_in = {root_ff[31:0], 1'b1};
            end else begin
               rem_in  = rem_sh[34:0];
               root_in = {root_ff[31:0], 1'b0};
            end
            rad_in = {rad_ff[63:0], 2'b00};
            it_in  = it_ff + 6'd1;
            if (it_ff == 6'd32) begin
               state_in = BK_APPEND;
            end
         end
         BK_APPEND: begin
            mem_we      = 1'b1;
            wr_addr     = AW'(cmd_ff.idx);
            wr_data     = {cmd_ff.x, cmd_ff.y, cmd_ff.speed, cum_new};
            last_x_in   = cmd_ff.x;
            last_y_in   = cmd_ff.y;
            last_cum_in = cum_new;
            state_in    = BK_IDLE;
         end
         BK_SRCH: begin
            if (({1'b0, s_ff} + (AW+1)'(1)) == {1'b0, e_ff}) begin
               state_in = BK_RD_S;
            end else begin
               rd_addr  = mid_sum[AW:1];
               mid_in   = mid_sum[AW:1];
               state_in = BK_SRCH_CMP;
            end
         end
         BK_SRCH_CMP: begin
            if (rd_q_ff.cum < cmd_ff.distance) begin
               s_in = mid_ff;
            end else begin
               e_in = mid_ff;
            end
            state_in = BK_SRCH;
         end
         BK_RD_S: begin
            rd_addr  = s_ff;
            state_in = BK_RD_E;
         end
         BK_RD_E: begin
            rd_addr  = e_ff;
            cs_in    = rd_q_ff.cum;
            xs_in    = rd_q_ff.x;
            ys_in    = rd_q_ff.y;
            state_in = BK_RD_T;
         end
         BK_RD_T: begin
            rd_addr  = AW'(cmd_ff.idx - ALP_IDX_W'(1));
            ce_in    = rd_q_ff.cum;
            xe_in    = rd_q_ff.x;
            ye_in    = rd_q_ff.y;
            state_in = BK_SEG;
         end
         BK_SEG: begin
            total_in = rd_q_ff.cum;
            if (ce_ff == cs_ff) begin
               res_x_in      = xs_ff;
               res_y_in      = ys_ff;
               res_status_in = STATUS_ZERO_SEG;
               if (rd_q_ff.cum == '0) begin
                  idx_in   = '0;
                  state_in = BK_SPD_RD;
               end else begin
                  state_in = BK_SPD_MUL;
               end
            end else begin
               res_status_in    = STATUS_OK;
               div_req.start    = 1'b1;
               div_req.dividend = {16'b0, cmd_ff.distance - cs_ff, 16'b0};
               div_req.divisor  = ce_ff - cs_ff;
               state_in         = BK_FRAC_DIV;
            end
         end
         BK_FRAC_DIV: begin
            if (div_rsp.done) begin
               frac_in  = div_rsp.quotient[47:0];
               axis_in  = 1'b0;
               state_in = BK_LERP_LO;
            end
         end
         BK_LERP_LO: begin
            plo_in   = mul_p;
            state_in = BK_LERP_HI;
         end
         BK_LERP_HI: begin
            phi_in   = mul_p[47:0];
            state_in = BK_LERP_SUM;
         end
         BK_LERP_SUM: begin
            if (!axis_ff) begin
               res_x_in = lerp_res;
               axis_in  = 1'b1;
               state_in = BK_LERP_LO;
            end else begin
               res_y_in = lerp_res;
               if (total_ff == '0) begin
                  idx_in   = '0;
                  state_in = BK_SPD_RD;
               end else begin
                  state_in = BK_SPD_MUL;
               end
            end
         end
         BK_SPD_MUL: begin
            div_req.start    = 1'b1;
            div_req.dividend = mul_p + 64'(total_ff) - 64'd1;
            div_req.divisor  = total_ff;
            state_in         = BK_SPD_DIV1;
         end
         BK_SPD_DIV1: begin
            if (div_rsp.done) begin
               div_req.start    = 1'b1;
               div_req.dividend = div_rsp.quotient;
               div_req.divisor  = 32'(cmd_ff.idx);
               state_in         = BK_SPD_DIV2;
            end
         end
         BK_SPD_DIV2: begin
            if (div_rsp.done) begin
               idx_in   = div_rsp.remainder[AW-1:0];
               state_in = BK_SPD_RD;
            end
         end
         BK_SPD_RD: begin
            rd_addr  = idx_ff;
            state_in = BK_SPD_CAP;
         end
         BK_SPD_CAP: begin
            res_speed_in = rd_q_ff.speed;
            state_in     = BK_RESULT;
         end
         BK_RESULT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.pos_x  = res_x_ff;
               rsp_in.pos_y  = res_y_ff;
               rsp_in.speed  = res_speed_ff;
               rsp_in.status = res_status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      rsp_valid = rsp_valid_ff;
      rsp_data  = rsp_ff;
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      last_x_ff     <= last_x_in;
      last_y_ff     <= last_y_in;
      last_cum_ff   <= last_cum_in;
      s_ff          <= s_in;
      e_ff          <= e_in;
      mid_ff        <= mid_in;
      idx_ff        <= idx_in;
      cs_ff         <= cs_in;
      ce_ff         <= ce_in;
      xs_ff         <= xs_in;
      xe_ff         <= xe_in;
      ys_ff         <= ys_in;
      ye_ff         <= ye_in;
      total_ff      <= total_in;
      sq_ff         <= sq_in;
      plo_ff        <= plo_in;
      phi_ff        <= phi_in;
      frac_ff       <= frac_in;
      rad_ff        <= rad_in;
      rem_ff        <= rem_in;
      root_ff       <= root_in;
      it_ff         <= it_in;
      axis_ff       <= axis_in;
      res_x_ff      <= res_x_in;
      res_y_ff      <= res_y_in;
      res_speed_ff  <= res_speed_in;
      res_status_ff <= res_status_in;
      rsp_ff        <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `ALP_ASSERT_IMP(a_div_start_idle, clock, reset, div_req.start, !div_rsp.busy)
   `ALP_ASSERT_IMP(a_search_order, clock, reset, state_ff == BK_SRCH_CMP, s_ff < e_ff)
   `ALP_ASSERT_NEXT(a_result_issued, clock, reset, (state_ff == BK_RESULT) && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && (state_ff == BK_IDLE))

endmodule

// File: rtl/arc_length_path_lookup_top.sv
// Arc length path lookup. A load item appends a waypoint; after the first point,
// the segment length is found by a one-bit-per-cycle square root. A query runs
// a binary search over the cumulative lengths, memory reads of the segment ends
// and the path total, one division for the segment fraction (none if the segment
// has zero length), a low multiply, high multiply and sum per axis to interpolate,
// one multiply and two more divisions for the speed index (none if the path has
// zero length). A query on a path of fewer than two points gives a FEW status
// with no search. A two-entry command queue lets new items be taken while the
// back end works, and the result register holds a finished item while the next is computed.
module arc_length_path_lookup_top
   import alp_pkg::*;
#(
   parameter int MAX_POINTS = ALP_MAX_POINTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic        push_valid, push_ready, pop_valid, pop_ready;
   cmd_type     push_cmd, pop_cmd;
   div_req_type div_req;
   div_rsp_type div_rsp;

   alp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   alp_queue #(.DEPTH(ALP_QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   alp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   alp_back #(.MAX_POINTS(MAX_POINTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (pop_valid),
      .q_ready   (pop_ready),
      .q_cmd     (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .div_req   (div_req),
      .div_rsp   (div_rsp)
   );

endmodule
